FILE: rtl/core/vna_pkg.sv
// shared types, widths and constants of the vertex normal accumulator
package vna_pkg;

  localparam int VERTEX_COUNT = 1024;
  localparam int IDX_W        = 10;
  localparam int COORD_W      = 16;
  localparam int SUM_W        = 24;
  localparam int NORM_W       = 16;
  localparam int EPOCH_W      = 8;
  localparam int IN_DATA_W    = 88;
  localparam int IN_USER_W    = 2;
  localparam int OUT_DATA_W   = 80;

  localparam logic [EPOCH_W-1:0] EpochFirst = EPOCH_W'(1);
  localparam logic [EPOCH_W-1:0] EpochLast  = {EPOCH_W{1'b1}};
  localparam logic [EPOCH_W-1:0] EpochNone  = '0;

  localparam logic KindFace = 1'b0;
  localparam logic KindSum  = 1'b1;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_CLEAR = 2'd1,
    OP_TRI   = 2'd2,
    OP_READ  = 2'd3
  } opcode_e;

  typedef struct packed {
    opcode_e                    op;
    logic [IDX_W-1:0]           vidx;
    logic [IDX_W-1:0]           ca;
    logic [IDX_W-1:0]           cb;
    logic [IDX_W-1:0]           cc;
    logic signed [COORD_W-1:0]  px;
    logic signed [COORD_W-1:0]  py;
    logic signed [COORD_W-1:0]  pz;
  } cmd_t;

  typedef struct packed {
    logic sweeping;
  } back_stat_t;

  typedef struct packed {
    logic                     clip;
    logic [EPOCH_W-1:0]       tag;
    logic signed [SUM_W-1:0]  sz;
    logic signed [SUM_W-1:0]  sy;
    logic signed [SUM_W-1:0]  sx;
  } sum_entry_t;

  typedef enum logic [3:0] {
    B_SWEEP,
    B_IDLE,
    B_VRD_A,
    B_VRD_B,
    B_VRD_C,
    B_VRD_W,
    B_NSTART,
    B_NWAIT,
    B_ACC_RD,
    B_ACC_WR,
    B_SUM_RD,
    B_SUM_DAT,
    B_EMIT
  } back_state_e;

  typedef enum logic [3:0] {
    N_IDLE,
    N_PROD,
    N_CROSS,
    N_SHIFT,
    N_SQUARE,
    N_ROOT,
    N_DIV_LOAD,
    N_DIVIDE,
    N_DONE
  } nrm_state_e;

endpackage

FILE: rtl/core/vna_front.sv
// front end: takes input beats, decodes them and queues commands for the back end
module vna_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_tvalid_i,
  output logic                          s_tready_o,
  input  logic [vna_pkg::IN_DATA_W-1:0] s_tdata_i,
  input  logic [vna_pkg::IN_USER_W-1:0] s_tuser_i,
  input  vna_pkg::back_stat_t           stat_i,
  output logic                          cmd_valid_o,
  output vna_pkg::cmd_t                 cmd_o,
  input  logic                          cmd_pop_i
);

  vna_pkg::cmd_t cmd_in;
  vna_pkg::cmd_t fifo_q [2];
  logic          wr_ptr_q, wr_ptr_d;
  logic          rd_ptr_q, rd_ptr_d;
  logic [1:0]    cnt_q, cnt_d;
  logic          push;
  logic          pop;

  always_comb begin
    cmd_in.op   = vna_pkg::opcode_e'(s_tuser_i);
    cmd_in.vidx = s_tdata_i[9:0];
    cmd_in.ca   = s_tdata_i[19:10];
    cmd_in.cb   = s_tdata_i[29:20];
    cmd_in.cc   = s_tdata_i[39:30];
    cmd_in.px   = s_tdata_i[55:40];
    cmd_in.py   = s_tdata_i[71:56];
    cmd_in.pz   = s_tdata_i[87:72];
  end

  assign s_tready_o  = (cnt_q != 2'd2) && !stat_i.sweeping;
  assign push        = s_tvalid_i && s_tready_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign pop         = cmd_pop_i && cmd_valid_o;
  assign cmd_o       = fifo_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push;
    rd_ptr_d = rd_ptr_q ^ pop;
    cnt_d    = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

FILE: rtl/core/vna_normal.sv
// face normal unit: edges, cross product, normalize, square root and division
module vna_normal (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [vna_pkg::COORD_W-1:0]  pa_i [3],
  input  logic signed [vna_pkg::COORD_W-1:0]  pb_i [3],
  input  logic signed [vna_pkg::COORD_W-1:0]  pc_i [3],
  output logic                                done_o,
  output logic signed [vna_pkg::NORM_W-1:0]   n_o [3],
  output logic                                degen_o
);

  localparam int EdgeW = vna_pkg::COORD_W + 1;
  localparam int ProdW = 2 * EdgeW;
  localparam int MagW  = ProdW;
  localparam int SqW   = 62;
  localparam int RootW = 64;
  localparam int LenW  = 31;
  localparam int NumW  = 45;
  localparam int QuoW  = 16;

  vna_pkg::nrm_state_e state_q, state_d;

  logic signed [EdgeW-1:0] e1_q [3];
  logic signed [EdgeW-1:0] e2_q [3];
  logic signed [ProdW-1:0] p_q [6];
  logic [MagW-1:0]         m_q [3];
  logic                    neg_q [3];
  logic                    degen_q;
  logic [SqW-1:0]          s_q;
  logic [RootW-1:0]        rem_q, root_q, bit_q;
  logic [LenW-1:0]         len_q;
  logic [LenW-1:0]         drem_q;
  logic [QuoW-1:0]         numlo_q;
  logic [QuoW-1:0]         quo_q;
  logic [3:0]              step_q;
  logic [1:0]              k_q;
  logic signed [vna_pkg::NORM_W-1:0] n_q [3];

  logic signed [ProdW:0] xprod [3];
  logic                  all_zero;
  logic                  too_big;
  logic                  too_small;
  logic [59:0]           sq;
  logic [RootW-1:0]      trial;
  logic                  root_ge;
  logic [NumW-1:0]       num;
  logic [LenW:0]         r2;
  logic                  div_ge;
  logic [QuoW-1:0]       quo_f;

  always_comb begin
    xprod[0] = {p_q[0][ProdW-1], p_q[0]} - {p_q[1][ProdW-1], p_q[1]};
    xprod[1] = {p_q[2][ProdW-1], p_q[2]} - {p_q[3][ProdW-1], p_q[3]};
    xprod[2] = {p_q[4][ProdW-1], p_q[4]} - {p_q[5][ProdW-1], p_q[5]};
    all_zero = (xprod[0] == '0) && (xprod[1] == '0) && (xprod[2] == '0);
    too_big   = (m_q[0][MagW-1:30] != '0) || (m_q[1][MagW-1:30] != '0)
             || (m_q[2][MagW-1:30] != '0);
    too_small = (m_q[0][MagW-1:29] == '0) && (m_q[1][MagW-1:29] == '0)
             && (m_q[2][MagW-1:29] == '0);
    sq      = m_q[k_q][29:0] * m_q[k_q][29:0];
    trial   = root_q + bit_q;
    root_ge = rem_q >= trial;
    num     = {1'b0, m_q[k_q][29:0], 14'b0} + NumW'(len_q >> 1);
    r2      = {drem_q, numlo_q[QuoW-1]};
    div_ge  = r2 >= {1'b0, len_q};
    quo_f   = {quo_q[QuoW-2:0], div_ge};
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      vna_pkg::N_IDLE:     if (start_i) state_d = vna_pkg::N_PROD;
      vna_pkg::N_PROD:     state_d = vna_pkg::N_CROSS;
      vna_pkg::N_CROSS:    state_d = all_zero ? vna_pkg::N_DONE : vna_pkg::N_SHIFT;
      vna_pkg::N_SHIFT:    if (!too_big && !too_small) state_d = vna_pkg::N_SQUARE;
      vna_pkg::N_SQUARE:   if (k_q == 2'd2) state_d = vna_pkg::N_ROOT;
      vna_pkg::N_ROOT:     if (bit_q[0]) state_d = vna_pkg::N_DIV_LOAD;
      vna_pkg::N_DIV_LOAD: state_d = vna_pkg::N_DIVIDE;
      vna_pkg::N_DIVIDE: begin
        if (step_q == 4'd15) begin
          state_d = (k_q == 2'd2) ? vna_pkg::N_DONE : vna_pkg::N_DIV_LOAD;
        end
      end
      vna_pkg::N_DONE:     state_d = vna_pkg::N_IDLE;
      default:             state_d = vna_pkg::N_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    done_o  = (state_q == vna_pkg::N_DONE);
    degen_o = degen_q;
    n_o     = n_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= vna_pkg::N_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      vna_pkg::N_IDLE: begin
        for (int i = 0; i < 3; i++) begin
          e1_q[i] <= EdgeW'(pb_i[i]) - EdgeW'(pa_i[i]);
          e2_q[i] <= EdgeW'(pc_i[i]) - EdgeW'(pa_i[i]);
        end
      end
      vna_pkg::N_PROD: begin
        p_q[0] <= e1_q[1] * e2_q[2];
        p_q[1] <= e1_q[2] * e2_q[1];
        p_q[2] <= e1_q[2] * e2_q[0];
        p_q[3] <= e1_q[0] * e2_q[2];
        p_q[4] <= e1_q[0] * e2_q[1];
        p_q[5] <= e1_q[1] * e2_q[0];
      end
      vna_pkg::N_CROSS: begin
        degen_q <= all_zero;
        for (int i = 0; i < 3; i++) begin
          neg_q[i] <= xprod[i][ProdW];
          m_q[i]   <= xprod[i][ProdW] ? MagW'(-xprod[i]) : MagW'(xprod[i]);
          n_q[i]   <= '0;
        end
        k_q <= 2'd0;
        s_q <= '0;
      end
      vna_pkg::N_SHIFT: begin
        for (int i = 0; i < 3; i++) begin
          if (too_big) begin
            m_q[i] <= m_q[i] >> 1;
          end else if (too_small) begin
            m_q[i] <= m_q[i] << 1;
          end
        end
      end
      vna_pkg::N_SQUARE: begin
        s_q <= s_q + SqW'(sq);
        k_q <= k_q + 2'd1;
        if (k_q == 2'd2) begin
          rem_q  <= RootW'(s_q + SqW'(sq));
          root_q <= '0;
          bit_q  <= RootW'(1) << 62;
        end
      end
      vna_pkg::N_ROOT: begin
        if (root_ge) begin
          rem_q  <= rem_q - trial;
          root_q <= (root_q >> 1) + bit_q;
        end else begin
          root_q <= root_q >> 1;
        end
        bit_q <= bit_q >> 2;
        if (bit_q[0]) begin
          len_q <= root_ge ? LenW'((root_q >> 1) + bit_q) : LenW'(root_q >> 1);
          k_q   <= 2'd0;
        end
      end
      vna_pkg::N_DIV_LOAD: begin
        drem_q  <= LenW'(num[NumW-1:QuoW]);
        numlo_q <= num[QuoW-1:0];
        quo_q   <= '0;
        step_q  <= 4'd0;
      end
      vna_pkg::N_DIVIDE: begin
        drem_q  <= div_ge ? LenW'(r2 - {1'b0, len_q}) : LenW'(r2);
        numlo_q <= numlo_q << 1;
        quo_q   <= quo_f;
        step_q  <= step_q + 4'd1;
        if (step_q == 4'd15) begin
          n_q[k_q] <= neg_q[k_q] ? -$signed(quo_f) : $signed(quo_f);
          k_q      <= k_q + 2'd1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: rtl/core/vna_back.sv
// back end: vertex and sum memories, command sequencer and output register
module vna_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cmd_valid_i,
  input  vna_pkg::cmd_t                  cmd_i,
  output logic                           cmd_pop_o,
  output vna_pkg::back_stat_t            stat_o,
  output logic                           m_tvalid_o,
  input  logic                           m_tready_i,
  output logic [vna_pkg::OUT_DATA_W-1:0] m_tdata_o,
  output logic                           m_tuser_o
);

  localparam int VtxW = 3 * vna_pkg::COORD_W;
  localparam int SumW = vna_pkg::SUM_W;

  vna_pkg::back_state_e state_q, state_d;
  vna_pkg::cmd_t        cmd_q;

  logic [VtxW-1:0]            vmem [vna_pkg::VERTEX_COUNT];
  vna_pkg::sum_entry_t        smem [vna_pkg::VERTEX_COUNT];
  logic [VtxW-1:0]            vrd_q;
  vna_pkg::sum_entry_t        srd_q;

  logic                       vmem_we;
  logic [vna_pkg::IDX_W-1:0]  vmem_wa, vmem_ra;
  logic                       smem_we;
  logic [vna_pkg::IDX_W-1:0]  smem_wa, smem_ra;
  vna_pkg::sum_entry_t        smem_wd;

  logic [vna_pkg::EPOCH_W-1:0] epoch_q;
  logic [vna_pkg::IDX_W-1:0]   sweep_idx_q;
  logic [1:0]                  corner_q;
  logic [vna_pkg::IDX_W-1:0]   corner_idx;

  logic signed [vna_pkg::COORD_W-1:0] pa_q [3];
  logic signed [vna_pkg::COORD_W-1:0] pb_q [3];
  logic signed [vna_pkg::COORD_W-1:0] pc_q [3];

  logic                               nrm_start;
  logic                               nrm_done;
  logic signed [vna_pkg::NORM_W-1:0]  nrm_n [3];
  logic                               nrm_degen;
  logic signed [vna_pkg::NORM_W-1:0]  face_q [3];

  logic                      res_kind_q;
  logic signed [SumW-1:0]    res_q [3];
  logic                      res_degen_q;
  logic                      res_sat_q;

  logic                      out_valid_q;
  logic [vna_pkg::OUT_DATA_W-1:0] out_data_q;
  logic                      out_user_q;
  logic                      out_free;

  logic                      entry_valid;
  logic signed [SumW-1:0]    base [3];
  logic                      base_clip;
  logic signed [SumW-1:0]    acc_new [3];
  logic [2:0]                acc_clip;

  function automatic logic [SumW:0] sat_add(logic signed [SumW-1:0] acc,
                                            logic signed [vna_pkg::NORM_W-1:0] add);
    logic signed [SumW:0] r;
    logic signed [SumW:0] hi;
    logic signed [SumW:0] lo;
    hi = (SumW+1)'({1'b0, {(SumW-1){1'b1}}});
    lo = -hi - (SumW+1)'(1);
    r  = {acc[SumW-1], acc} + (SumW+1)'(add);
    if (r > hi) begin
      return {1'b1, hi[SumW-1:0]};
    end else if (r < lo) begin
      return {1'b1, lo[SumW-1:0]};
    end
    return {1'b0, r[SumW-1:0]};
  endfunction

  vna_normal u_normal (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (nrm_start),
    .pa_i    (pa_q),
    .pb_i    (pb_q),
    .pc_i    (pc_q),
    .done_o  (nrm_done),
    .n_o     (nrm_n),
    .degen_o (nrm_degen)
  );

  assign out_free = !out_valid_q || m_tready_i;

  always_comb begin
    case (corner_q)
      2'd0:    corner_idx = cmd_q.ca;
      2'd1:    corner_idx = cmd_q.cb;
      default: corner_idx = cmd_q.cc;
    endcase
  end

  // an entry written under an older epoch reads as a cleared sum
  always_comb begin
    logic [SumW:0] t;
    entry_valid = (srd_q.tag == epoch_q);
    base[0]     = entry_valid ? srd_q.sx : '0;
    base[1]     = entry_valid ? srd_q.sy : '0;
    base[2]     = entry_valid ? srd_q.sz : '0;
    base_clip   = entry_valid && srd_q.clip;
    for (int i = 0; i < 3; i++) begin
      t           = sat_add(base[i], face_q[i]);
      acc_clip[i] = t[SumW];
      acc_new[i]  = t[SumW-1:0];
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      vna_pkg::B_SWEEP: begin
        if (sweep_idx_q == {vna_pkg::IDX_W{1'b1}}) state_d = vna_pkg::B_IDLE;
      end
      vna_pkg::B_IDLE: begin
        if (cmd_valid_i) begin
          unique case (cmd_i.op)
            vna_pkg::OP_WRITE: state_d = vna_pkg::B_IDLE;
            vna_pkg::OP_CLEAR: begin
              state_d = (epoch_q == vna_pkg::EpochLast) ? vna_pkg::B_SWEEP : vna_pkg::B_IDLE;
            end
            vna_pkg::OP_TRI:   state_d = vna_pkg::B_VRD_A;
            vna_pkg::OP_READ:  state_d = vna_pkg::B_SUM_RD;
            default:           state_d = vna_pkg::B_IDLE;
          endcase
        end
      end
      vna_pkg::B_VRD_A:   state_d = vna_pkg::B_VRD_B;
      vna_pkg::B_VRD_B:   state_d = vna_pkg::B_VRD_C;
      vna_pkg::B_VRD_C:   state_d = vna_pkg::B_VRD_W;
      vna_pkg::B_VRD_W:   state_d = vna_pkg::B_NSTART;
      vna_pkg::B_NSTART:  state_d = vna_pkg::B_NWAIT;
      vna_pkg::B_NWAIT:   if (nrm_done) state_d = vna_pkg::B_ACC_RD;
      vna_pkg::B_ACC_RD:  state_d = vna_pkg::B_ACC_WR;
      vna_pkg::B_ACC_WR: begin
        state_d = (corner_q == 2'd2) ? vna_pkg::B_EMIT : vna_pkg::B_ACC_RD;
      end
      vna_pkg::B_SUM_RD:  state_d = vna_pkg::B_SUM_DAT;
      vna_pkg::B_SUM_DAT: state_d = vna_pkg::B_EMIT;
      vna_pkg::B_EMIT:    if (out_free) state_d = vna_pkg::B_IDLE;
      default:            state_d = vna_pkg::B_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    cmd_pop_o       = (state_q == vna_pkg::B_IDLE) && cmd_valid_i;
    stat_o.sweeping = (state_q == vna_pkg::B_SWEEP);
    nrm_start       = (state_q == vna_pkg::B_NSTART);
    vmem_we         = cmd_pop_o && (cmd_i.op == vna_pkg::OP_WRITE);
    vmem_wa         = cmd_i.vidx;
    unique case (state_q)
      vna_pkg::B_VRD_A: vmem_ra = cmd_q.ca;
      vna_pkg::B_VRD_B: vmem_ra = cmd_q.cb;
      default:          vmem_ra = cmd_q.cc;
    endcase
    smem_we    = 1'b0;
    smem_wa    = corner_idx;
    smem_ra    = (state_q == vna_pkg::B_SUM_RD) ? cmd_q.vidx : corner_idx;
    smem_wd.clip = base_clip || (acc_clip != 3'b000);
    smem_wd.tag  = epoch_q;
    smem_wd.sx   = acc_new[0];
    smem_wd.sy   = acc_new[1];
    smem_wd.sz   = acc_new[2];
    if (state_q == vna_pkg::B_SWEEP) begin
      smem_we     = 1'b1;
      smem_wa     = sweep_idx_q;
      smem_wd.tag = vna_pkg::EpochNone;
    end else if (state_q == vna_pkg::B_ACC_WR) begin
      smem_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vmem_we) begin
      vmem[vmem_wa] <= {cmd_i.pz, cmd_i.py, cmd_i.px};
    end
    vrd_q <= vmem[vmem_ra];
  end

  always_ff @(posedge clk_i) begin
    if (smem_we) begin
      smem[smem_wa] <= smem_wd;
    end
    srd_q <= smem[smem_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= vna_pkg::B_SWEEP;
      epoch_q     <= vna_pkg::EpochFirst;
      sweep_idx_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == vna_pkg::B_SWEEP) begin
        sweep_idx_q <= sweep_idx_q + 1'b1;
      end
      if (cmd_pop_o && (cmd_i.op == vna_pkg::OP_CLEAR)) begin
        epoch_q <= (epoch_q == vna_pkg::EpochLast) ? vna_pkg::EpochFirst : epoch_q + 1'b1;
      end
      if ((state_q == vna_pkg::B_EMIT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      cmd_q <= cmd_i;
    end
    case (state_q)
      vna_pkg::B_VRD_B: begin
        {pa_q[2], pa_q[1], pa_q[0]} <= vrd_q;
      end
      vna_pkg::B_VRD_C: begin
        {pb_q[2], pb_q[1], pb_q[0]} <= vrd_q;
      end
      vna_pkg::B_VRD_W: begin
        {pc_q[2], pc_q[1], pc_q[0]} <= vrd_q;
      end
      vna_pkg::B_NWAIT: begin
        if (nrm_done) begin
          face_q      <= nrm_n;
          res_kind_q  <= vna_pkg::KindFace;
          res_degen_q <= nrm_degen;
          res_sat_q   <= 1'b0;
          corner_q    <= 2'd0;
          for (int i = 0; i < 3; i++) begin
            res_q[i] <= SumW'(nrm_n[i]);
          end
        end
      end
      vna_pkg::B_ACC_WR: begin
        res_sat_q <= res_sat_q || (acc_clip != 3'b000);
        corner_q  <= corner_q + 2'd1;
      end
      vna_pkg::B_SUM_DAT: begin
        res_kind_q  <= vna_pkg::KindSum;
        res_degen_q <= 1'b0;
        res_sat_q   <= base_clip;
        res_q       <= base;
      end
      default: begin
      end
    endcase
    if ((state_q == vna_pkg::B_EMIT) && out_free) begin
      out_user_q <= res_kind_q;
      out_data_q <= {6'b0, res_sat_q, res_degen_q, res_q[2], res_q[1], res_q[0]};
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_data_q;
  assign m_tuser_o  = out_user_q;

endmodule

FILE: rtl/core/vertex_normal_accumulator_top.sv
// top level of the vertex normal accumulator
//
//  channel  dir  tdata                                    tuser
//  s_axis   in   88b index, corners a/b/c, pos x/y/z      2b opcode
//  m_axis   out  80b norm x/y/z, degenerate, saturated    1b result kind
//
// a triangle goes through three vertex reads, the normal unit
// (about 29 shift steps worst case, 32 square root steps, three divides)
// and three read/write passes over the single sum memory
// writes and clears complete in the idle state of the back end; reads go through the sum read, sum data and emit states
// after reset, and after every 255th clear, a sweep over all 1024 entries retags the sum
// memory; no beat is taken during it
// a two deep command queue and the output register let the input and output
// sides stall on their own
module vertex_normal_accumulator_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // vertex_index, corner_a, corner_b, corner_c, pos_x, pos_y, pos_z
  input  logic [vna_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // opcode
  input  logic [vna_pkg::IN_USER_W-1:0]  s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // norm_x, norm_y, norm_z, degenerate, saturated, zero fill
  output logic [vna_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // result_kind
  output logic                           m_axis_tuser
);

  vna_pkg::back_stat_t stat;
  vna_pkg::cmd_t       cmd;
  logic                cmd_valid;
  logic                cmd_pop;

  // decode and queue
  vna_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_o  (s_axis_tready),
    .s_tdata_i   (s_axis_tdata),
    .s_tuser_i   (s_axis_tuser),
    .stat_i      (stat),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  // memories, face normal and accumulation
  vna_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .stat_o      (stat),
    .m_tvalid_o  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_o   (m_axis_tdata),
    .m_tuser_o   (m_axis_tuser)
  );

`ifndef SYNTH
  // no beat is taken while the sum memory is being retagged
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.sweeping |-> !s_axis_tready)
    else $error("beat accepted during sweep");

  // a degenerate face carries a zero normal
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == vna_pkg::KindFace) && m_axis_tdata[72])
      |-> (m_axis_tdata[71:0] == '0))
    else $error("degenerate face with nonzero normal");

  // sum reads never flag degenerate
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == vna_pkg::KindSum)) |-> !m_axis_tdata[72])
    else $error("sum read flagged degenerate");
`endif

endmodule
